// ===== hw/rtl/pdm_pkg.sv =====
// Shared types and constants for the pose delta to motion block.
package pdm_pkg;

  // Fraction bits of the rotation entries (Q2.14).
  localparam int ROT_FRAC = 14;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PIVOT_X  = 3'd0;
  localparam cfg_idx_t CFG_PIVOT_Y  = 3'd1;
  localparam cfg_idx_t CFG_PIVOT_Z  = 3'd2;
  localparam cfg_idx_t CFG_MAX_STEP = 3'd3;
  localparam cfg_idx_t CFG_GAP_MS   = 3'd4;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    OP_DMAT = 3'd0,
    OP_ORB  = 3'd1,
    OP_LIM  = 3'd2,
    OP_MAG  = 3'd3,
    OP_PROJ = 3'd4
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       flag_evt;
    logic       seed;
    logic       issue;
    op_t        op;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] k;
    logic       first;
    logic       last;
  } pdm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic motion_on;
    logic have_ref;
    logic gap_over;
    logic step_over;
  } pdm_stat_t;

endpackage

// ===== hw/rtl/pdm_in_if.sv =====
// Input channel interface: one pose or motion flag event per transfer.
interface pdm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               motion_on;
  logic        [47:0] rot_row0;
  logic        [47:0] rot_row1;
  logic        [47:0] rot_row2;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [31:0] now_ms;

  modport source (output valid, mode, motion_on, rot_row0, rot_row1, rot_row2,
                  pos_x, pos_y, pos_z, now_ms, input ready);
  modport sink (input valid, mode, motion_on, rot_row0, rot_row1, rot_row2,
                pos_x, pos_y, pos_z, now_ms, output ready);
endinterface

// ===== hw/rtl/pdm_out_if.sv =====
// Result channel interface: one six-axis motion step per transfer.
interface pdm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] move_x;
  logic signed [31:0] move_y;
  logic signed [31:0] move_z;
  logic signed [15:0] turn_x;
  logic signed [15:0] turn_y;
  logic signed [15:0] turn_z;

  modport source (output valid, move_x, move_y, move_z, turn_x, turn_y, turn_z,
                  input ready);
  modport sink (input valid, move_x, move_y, move_z, turn_x, turn_y, turn_z,
                output ready);
endinterface

// ===== hw/rtl/pdm_dpath.sv =====
// Datapath: reference store, configuration, shared multiplier and accumulator.
module pdm_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_wdata,
  input  logic               in_mode,
  input  logic               in_motion_on,
  input  logic        [47:0] in_rot_row0,
  input  logic        [47:0] in_rot_row1,
  input  logic        [47:0] in_rot_row2,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic        [31:0] in_now_ms,
  input  pdm_pkg::pdm_cmd_t  cmd,
  output pdm_pkg::pdm_stat_t stat,
  output logic signed [31:0] move_x,
  output logic signed [31:0] move_y,
  output logic signed [31:0] move_z,
  output logic signed [15:0] turn_x,
  output logic signed [15:0] turn_y,
  output logic signed [15:0] turn_z
);
  import pdm_pkg::*;

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] v;
    v = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] res;
    if (v > 37'sd2147483647) res = 32'sh7fffffff;
    else if (v < -37'sd2147483648) res = 32'sh80000000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] res;
    if (v > 21'sd32767) res = 16'sh7fff;
    else if (v < -21'sd32768) res = 16'sh8000;
    else res = v[15:0];
    return res;
  endfunction

  localparam logic signed [65:0] HALF_LSB = 66'sd1 <<< (ROT_FRAC - 1);

  // Configuration.
  logic signed [31:0] piv_r [3];
  logic        [30:0] max_r;
  logic        [15:0] gap_r;

  // Latched item and reference.
  logic signed [15:0] n_r   [9];
  logic signed [15:0] ref_r [9];
  logic signed [31:0] p_r   [3];
  logic signed [31:0] refp_r[3];
  logic               mode_r;
  logic               mon_r;
  logic        [31:0] now_r;
  logic               have_ref_r;
  logic        [31:0] last_r;

  // Intermediate results.
  logic signed [33:0] d_r    [9];
  logic signed [43:0] delta_r[3];
  logic signed [35:0] t_r    [3];
  logic               big_r;
  logic        [61:0] lim2_r;
  logic        [63:0] mag2_r;

  // Multiplier pipeline.
  logic signed [32:0] a_op;
  logic signed [32:0] b_op;
  logic signed [65:0] prod_r;
  logic signed [65:0] acc_r;
  pdm_cmd_t           cmd_d_r;
  logic               vld_d_r;

  logic signed [65:0] sum;
  logic signed [65:0] sum_rnd;
  logic signed [43:0] delta_n;
  logic               big_n;
  logic signed [33:0] d_sel;
  logic signed [34:0] d_rnd;
  logic        [31:0] elapsed;

  // Operand selection.
  always_comb begin
    d_sel = d_r[idx3(cmd.i, cmd.k)];
    d_rnd = {d_sel[33], d_sel} + (35'sd1 <<< (ROT_FRAC - 1));
    unique case (cmd.op)
      OP_DMAT: begin
        a_op = {{17{n_r[idx3(cmd.i, cmd.k)][15]}}, n_r[idx3(cmd.i, cmd.k)]};
        b_op = {{17{ref_r[idx3(cmd.j, cmd.k)][15]}}, ref_r[idx3(cmd.j, cmd.k)]};
      end
      OP_ORB: begin
        a_op = {{12{d_rnd[34]}}, d_rnd[34:ROT_FRAC]};
        b_op = {refp_r[cmd.k][31], refp_r[cmd.k]} - {piv_r[cmd.k][31], piv_r[cmd.k]};
      end
      OP_LIM: begin
        a_op = {2'b00, max_r};
        b_op = {2'b00, max_r};
      end
      OP_MAG: begin
        a_op = delta_r[cmd.k][32:0];
        b_op = delta_r[cmd.k][32:0];
      end
      OP_PROJ: begin
        a_op = {{17{ref_r[idx3(cmd.i, cmd.k)][15]}}, ref_r[idx3(cmd.i, cmd.k)]};
        b_op = delta_r[cmd.k][32:0];
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // Accumulate stage and the orbit-corrected step of the current row.
  always_comb begin
    sum     = cmd_d_r.first ? prod_r : acc_r + prod_r;
    sum_rnd = sum + HALF_LSB;
    delta_n = {{12{p_r[cmd_d_r.i][31]}}, p_r[cmd_d_r.i]}
            - {{12{piv_r[cmd_d_r.i][31]}}, piv_r[cmd_d_r.i]}
            - {{2{sum_rnd[55]}}, sum_rnd[55:ROT_FRAC]};
    big_n   = (delta_n[43:31] != {13{delta_n[31]}})
            | (delta_n[31] & (delta_n[30:0] == 31'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piv_r[0]   <= '0;
      piv_r[1]   <= '0;
      piv_r[2]   <= '0;
      max_r      <= 31'd655360;
      gap_r      <= 16'd500;
      have_ref_r <= 1'b0;
      last_r     <= '0;
      vld_d_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIVOT_X:  piv_r[0] <= cfg_wdata;
          CFG_PIVOT_Y:  piv_r[1] <= cfg_wdata;
          CFG_PIVOT_Z:  piv_r[2] <= cfg_wdata;
          CFG_MAX_STEP: max_r    <= cfg_wdata[30:0];
          CFG_GAP_MS:   gap_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (cmd.flag_evt && mon_r) begin
        have_ref_r <= 1'b0;
        last_r     <= now_r;
      end
      if (cmd.seed) begin
        have_ref_r <= 1'b1;
        last_r     <= now_r;
      end
      vld_d_r <= cmd.issue;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int c = 0; c < 3; c++) begin
        n_r[c]     <= in_rot_row0[16*c +: 16];
        n_r[3 + c] <= in_rot_row1[16*c +: 16];
        n_r[6 + c] <= in_rot_row2[16*c +: 16];
      end
      p_r[0] <= in_pos_x;
      p_r[1] <= in_pos_y;
      p_r[2] <= in_pos_z;
      mode_r <= in_mode;
      mon_r  <= in_motion_on;
      now_r  <= in_now_ms;
      big_r  <= 1'b0;
    end
    if (cmd.seed) begin
      for (int e = 0; e < 9; e++) ref_r[e] <= n_r[e];
      for (int c = 0; c < 3; c++) refp_r[c] <= p_r[c];
    end
    if (cmd.issue) begin
      prod_r  <= a_op * b_op;
      cmd_d_r <= cmd;
    end
    if (vld_d_r) begin
      acc_r <= sum;
      if (cmd_d_r.last) begin
        unique case (cmd_d_r.op)
          OP_DMAT: d_r[idx3(cmd_d_r.i, cmd_d_r.j)] <= sum[33:0];
          OP_ORB: begin
            delta_r[cmd_d_r.i] <= delta_n;
            if (big_n) big_r <= 1'b1;
          end
          OP_LIM:  lim2_r <= sum[61:0];
          OP_MAG:  mag2_r <= sum[63:0];
          OP_PROJ: t_r[cmd_d_r.i] <= sum_rnd[49:ROT_FRAC];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    elapsed        = now_r - last_r;
    stat.mode      = mode_r;
    stat.motion_on = mon_r;
    stat.have_ref  = have_ref_r;
    stat.gap_over  = elapsed > {16'd0, gap_r};
    stat.step_over = big_r | (mag2_r > {2'b00, lim2_r});
  end

  // Result fields come straight from the stored sums.
  logic signed [35:0] tx_diff;
  logic signed [35:0] ty_diff;
  logic signed [35:0] tz_diff;
  always_comb begin
    move_x  = sat32(-{t_r[0][35], t_r[0]});
    move_y  = sat32(-{t_r[1][35], t_r[1]});
    move_z  = sat32({t_r[2][35], t_r[2]});
    tx_diff = {{2{d_r[5][33]}}, d_r[5]} - {{2{d_r[7][33]}}, d_r[7]}
            + (36'sd1 <<< ROT_FRAC);
    ty_diff = {{2{d_r[6][33]}}, d_r[6]} - {{2{d_r[2][33]}}, d_r[2]}
            + (36'sd1 <<< ROT_FRAC);
    tz_diff = {{2{d_r[1][33]}}, d_r[1]} - {{2{d_r[3][33]}}, d_r[3]}
            + (36'sd1 <<< ROT_FRAC);
    turn_x  = sat16(tx_diff[35:ROT_FRAC + 1]);
    turn_y  = sat16(ty_diff[35:ROT_FRAC + 1]);
    turn_z  = sat16(tz_diff[35:ROT_FRAC + 1]);
  end

endmodule

// ===== hw/rtl/pdm_ctrl.sv =====
// Controller: sequences the multiply-accumulate passes and the handshakes.
module pdm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pdm_pkg::pdm_stat_t stat,
  output pdm_pkg::pdm_cmd_t  cmd
);
  import pdm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_CHECK  = 11'b00000000010,
    ST_DMAT   = 11'b00000000100,
    ST_ORB    = 11'b00000001000,
    ST_LIM    = 11'b00000010000,
    ST_MAG    = 11'b00000100000,
    ST_MWAIT  = 11'b00001000000,
    ST_DECIDE = 11'b00010000000,
    ST_PROJ   = 11'b00100000000,
    ST_PWAIT  = 11'b01000000000,
    ST_OUT    = 11'b10000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.op    = OP_DMAT;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.k     = k_r;
    cmd.first = (k_r == 2'd0);
    cmd.last  = (k_r == 2'd2);
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        i_nxt = 2'd0;
        j_nxt = 2'd0;
        k_nxt = 2'd0;
        if (!stat.mode) begin
          cmd.flag_evt = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (!stat.have_ref || stat.gap_over) begin
          cmd.seed  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DMAT;
        end
      end
      ST_DMAT: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = 2'd0;
          j_nxt = j_r + 2'd1;
          if (j_r == 2'd2) begin
            j_nxt = 2'd0;
            i_nxt = i_r + 2'd1;
            if (i_r == 2'd2) begin
              i_nxt     = 2'd0;
              state_nxt = ST_ORB;
            end
          end
        end
      end
      ST_ORB, ST_PROJ: begin
        cmd.issue = 1'b1;
        cmd.op    = (state_r == ST_ORB) ? OP_ORB : OP_PROJ;
        k_nxt     = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt = 2'd0;
          i_nxt = i_r + 2'd1;
          if (i_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = (state_r == ST_ORB) ? ST_LIM : ST_PWAIT;
          end
        end
      end
      ST_LIM: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_LIM;
        cmd.first = 1'b1;
        cmd.last  = 1'b1;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        cmd.issue = 1'b1;
        cmd.op    = OP_MAG;
        k_nxt     = k_r + 2'd1;
        if (k_r == 2'd2) begin
          k_nxt     = 2'd0;
          state_nxt = ST_MWAIT;
        end
      end
      ST_MWAIT: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.step_over) begin
          cmd.seed  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PROJ;
        end
      end
      ST_PWAIT: begin
        cmd.seed  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

// ===== hw/rtl/pose_delta_to_motion_core.sv =====
// Top level of the pose delta to motion block: controller plus datapath.
//
//   Channel   Direction  Moves per transfer
//   in_ch     in         motion flag event or camera pose (rotation, position, time)
//   out_ch    out        six-axis motion step (three moves, three turns)
//   cfg_*     in         one register write per enabled cycle, no read-back
//
// A motion flag event, or a pose that only re-seeds the reference, is done
// once it is checked; a pose that turns out too large runs the matrix, orbit,
// limit and magnitude passes, and a pose that yields a step also runs the
// projection pass and then waits for the result transfer. The time is set by
// the single shared 33 by 33 bit multiplier, which runs the 49 products of a step one after the other.
// Reset is synchronous and active low; it clears the control state, the pivot
// registers and the reference-valid flag, and loads the default step limit and
// gap. One item is in flight at a time: in_ch is ready only while idle, and a
// stalled result holds the block until out_ch takes it.
module pose_delta_to_motion_core (
  input  logic        clk,
  input  logic        rst_n,
  pdm_in_if.sink      in_ch,
  pdm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pdm_pkg::*;

  pdm_cmd_t  cmd;
  pdm_stat_t stat;

  // The controller owns both handshakes and steps the datapath.
  pdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the reference pose and works the sums; its result
  // registers stay stable while the result waits for its transfer.
  pdm_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (in_ch.mode),
    .in_motion_on (in_ch.motion_on),
    .in_rot_row0  (in_ch.rot_row0),
    .in_rot_row1  (in_ch.rot_row1),
    .in_rot_row2  (in_ch.rot_row2),
    .in_pos_x     (in_ch.pos_x),
    .in_pos_y     (in_ch.pos_y),
    .in_pos_z     (in_ch.pos_z),
    .in_now_ms    (in_ch.now_ms),
    .cmd          (cmd),
    .stat         (stat),
    .move_x       (out_ch.move_x),
    .move_y       (out_ch.move_y),
    .move_z       (out_ch.move_z),
    .turn_x       (out_ch.turn_x),
    .turn_y       (out_ch.turn_y),
    .turn_z       (out_ch.turn_z)
  );

endmodule
